// File: hdl/srf_pkg.sv
// Shared types and constants for the Schlick reflectance pipeline.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package srf_pkg;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16   = 17'h1_0000;
	localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
	localparam logic signed [33:0] ONE_Q28 = 34'sh1000_0000;
	localparam logic [33:0] HALF_Q17  = 34'h1_0000;
	localparam logic [15:0] R_ONE_Q15 = 16'h8000;

	// Quotient bits of each long division, root bits of the square root
	localparam int DIV_STEPS  = 33;
	localparam int SQRT_STEPS = 17;

	// Input word
	typedef struct packed {
		logic signed [15:0] eye_x;
		logic signed [15:0] eye_y;
		logic signed [15:0] eye_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [13:0]        index_from;
		logic [13:0]        index_to;
	} item_t;

	// Result word
	typedef struct packed {
		logic [15:0] reflectance;
		logic        total_internal;
	} result_t;

	// Front end to divider
	typedef struct packed {
		logic        tir;
		logic        gt;
		logic        den_zero;
		logic        sum_zero;
		logic [16:0] c;
		logic [59:0] num;
		logic [27:0] den;
		logic [27:0] dsq;
		logic [29:0] ssq;
	} div_in_t;

	// Divider to square root
	typedef struct packed {
		logic        tir;
		logic        gt;
		logic [16:0] c;
		logic [32:0] sin2;
		logic [32:0] r0;
	} sqrt_in_t;

	// Square root to back end
	typedef struct packed {
		logic        tir;
		logic [16:0] c;
		logic [32:0] r0;
	} back_in_t;

endpackage

`default_nettype wire

// File: hdl/srf_front.sv
// Front end: dot product, clamp, 1-c^2, n1^2*(1-c^2) and the total internal
// reflection test. Five register stages. Depends on srf_pkg.
`default_nettype none

module srf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire srf_pkg::item_t  in_word,
	output logic                 out_valid,
	output srf_pkg::div_in_t     out_word
);
	import srf_pkg::*;

	// Stage 1: products, index squares, index difference and sum
	logic signed [31:0] px, py, pz;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [27:0] n1sq_s1, n2sq_s1;
	logic [13:0] d_s1;
	logic [14:0] s_s1;
	logic        gt_s1, vld_s1;

	assign px = $signed(in_word.eye_x) * $signed(in_word.normal_x);
	assign py = $signed(in_word.eye_y) * $signed(in_word.normal_y);
	assign pz = $signed(in_word.eye_z) * $signed(in_word.normal_z);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= px;
			py_s1   <= py;
			pz_s1   <= pz;
			n1sq_s1 <= 28'(in_word.index_from) * 28'(in_word.index_from);
			n2sq_s1 <= 28'(in_word.index_to) * 28'(in_word.index_to);
			gt_s1   <= in_word.index_from > in_word.index_to;
			d_s1    <= (in_word.index_from > in_word.index_to) ?
				in_word.index_from - in_word.index_to :
				in_word.index_to - in_word.index_from;
			s_s1    <= 15'(in_word.index_from) + 15'(in_word.index_to);
		end
	end

	// Stage 2: sum and clamp to [0,1], squares of index difference and sum
	logic signed [33:0] dot;
	logic [16:0] c;
	logic [16:0] c_s2;
	logic [27:0] n1sq_s2, n2sq_s2, dsq_s2;
	logic [29:0] ssq_s2;
	logic        gt_s2, vld_s2;

	assign dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);

	always_comb begin
		if (dot < 34'sd0) begin
			c = '0;
		end else if (dot > ONE_Q28) begin
			c = ONE_Q16;
		end else begin
			c = dot[28:12];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= c;
			n1sq_s2 <= n1sq_s1;
			n2sq_s2 <= n2sq_s1;
			dsq_s2  <= 28'(d_s1) * 28'(d_s1);
			ssq_s2  <= 30'(s_s1) * 30'(s_s1);
			gt_s2   <= gt_s1;
		end
	end

	// Stage 3: 1 - c^2 in Q1.32
	logic [33:0] csq;
	logic [32:0] omc2_s3;
	logic [16:0] c_s3;
	logic [27:0] n1sq_s3, n2sq_s3, dsq_s3;
	logic [29:0] ssq_s3;
	logic        gt_s3, vld_s3;

	assign csq = 34'(c_s2) * 34'(c_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			omc2_s3 <= 33'(34'(ONE_Q32) - csq);
			c_s3    <= c_s2;
			n1sq_s3 <= n1sq_s2;
			n2sq_s3 <= n2sq_s2;
			dsq_s3  <= dsq_s2;
			ssq_s3  <= ssq_s2;
			gt_s3   <= gt_s2;
		end
	end

	// Stage 4: n1^2 * (1 - c^2); a full one is a plain shift
	logic [59:0] num_s4;
	logic [16:0] c_s4;
	logic [27:0] n2sq_s4, dsq_s4;
	logic [29:0] ssq_s4;
	logic        gt_s4, vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= omc2_s3[32] ? {n1sq_s3, 32'h0} :
				60'(n1sq_s3) * 60'(omc2_s3[31:0]);
			c_s4    <= c_s3;
			n2sq_s4 <= n2sq_s3;
			dsq_s4  <= dsq_s3;
			ssq_s4  <= ssq_s3;
			gt_s4   <= gt_s3;
		end
	end

	// Stage 5: total internal reflection test, exact
	always_ff @(posedge clk) begin
		if (en) begin
			out_word.tir      <= gt_s4 && (num_s4 > {n2sq_s4, 32'h0});
			out_word.gt       <= gt_s4;
			out_word.den_zero <= n2sq_s4 == '0;
			out_word.sum_zero <= ssq_s4 == '0;
			out_word.c        <= c_s4;
			out_word.num      <= num_s4;
			out_word.den      <= n2sq_s4;
			out_word.dsq      <= dsq_s4;
			out_word.ssq      <= ssq_s4;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_valid <= vld_s4;
		end
	end

endmodule

`default_nettype wire

// File: hdl/srf_div.sv
// Two restoring long dividers side by side, one quotient bit per stage:
// sin2_t = num / n2^2 and r0 = (d^2 << 32) / s^2. Depends on srf_pkg.
`default_nettype none

module srf_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire srf_pkg::div_in_t in_word,
	output logic                  out_valid,
	output srf_pkg::sqrt_in_t     out_word
);
	import srf_pkg::*;

	typedef struct packed {
		div_in_t     side;
		logic [27:0] rem_a;
		logic [29:0] rem_b;
		logic [32:0] q_a;
		logic [32:0] q_b;
	} div_st_t;

	div_st_t init;
	div_st_t stage_s [DIV_STEPS];
	logic    vld_s   [DIV_STEPS];

	// Upper dividend bits seed the remainders
	always_comb begin
		init.side  = in_word;
		init.rem_a = {1'b0, in_word.num[59:33]};
		init.rem_b = {3'b0, in_word.dsq[27:1]};
		init.q_a   = '0;
		init.q_b   = '0;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int BitIdx = DIV_STEPS - 1 - k;
		div_st_t     cur, nxt;
		logic        vin, bit_b, ge_a, ge_b;
		logic [28:0] ta;
		logic [30:0] tb;

		if (k == 0) begin : g_first
			assign cur = init;
			assign vin = in_valid;
		end else begin : g_next
			assign cur = stage_s[k-1];
			assign vin = vld_s[k-1];
		end

		// Only the lowest bit of d^2 lands in the quotient range
		assign bit_b = (BitIdx == DIV_STEPS - 1) ? cur.side.dsq[0] : 1'b0;
		assign ta    = {cur.rem_a, cur.side.num[BitIdx]};
		assign tb    = {cur.rem_b, bit_b};
		assign ge_a  = ta >= {1'b0, cur.side.den};
		assign ge_b  = tb >= {1'b0, cur.side.ssq};

		always_comb begin
			nxt.side  = cur.side;
			nxt.rem_a = ge_a ? 28'(ta - {1'b0, cur.side.den}) : ta[27:0];
			nxt.rem_b = ge_b ? 30'(tb - {1'b0, cur.side.ssq}) : tb[29:0];
			nxt.q_a   = {cur.q_a[31:0], ge_a};
			nxt.q_b   = {cur.q_b[31:0], ge_b};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end
	end

	// Zero divisors and clamp to one
	div_st_t last;
	assign last      = stage_s[DIV_STEPS-1];
	assign out_valid = vld_s[DIV_STEPS-1];

	always_comb begin
		out_word.tir = last.side.tir;
		out_word.gt  = last.side.gt;
		out_word.c   = last.side.c;
		if (last.side.den_zero) begin
			out_word.sin2 = '0;
		end else if (last.q_a > ONE_Q32) begin
			out_word.sin2 = ONE_Q32;
		end else begin
			out_word.sin2 = last.q_a;
		end
		if (last.side.sum_zero) begin
			out_word.r0 = '0;
		end else if (last.q_b > ONE_Q32) begin
			out_word.r0 = ONE_Q32;
		end else begin
			out_word.r0 = last.q_b;
		end
	end

endmodule

`default_nettype wire

// File: hdl/srf_sqrt.sv
// Square root of 1 - sin2_t, one root bit per stage after a setup stage,
// and the choice of the transmitted or incident cosine. Depends on srf_pkg.
`default_nettype none

module srf_sqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire srf_pkg::sqrt_in_t in_word,
	output logic                   out_valid,
	output srf_pkg::back_in_t      out_word
);
	import srf_pkg::*;

	typedef struct packed {
		logic        tir;
		logic        gt;
		logic [16:0] c;
		logic [32:0] r0;
		logic [33:0] x;
		logic [18:0] rem;
		logic [16:0] root;
	} sq_st_t;

	// Setup stage: radicand 1 - sin2_t
	sq_st_t prep_s0;
	logic   vld_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s0.tir  <= in_word.tir;
			prep_s0.gt   <= in_word.gt;
			prep_s0.c    <= in_word.c;
			prep_s0.r0   <= in_word.r0;
			prep_s0.x    <= 34'(ONE_Q32 - in_word.sin2);
			prep_s0.rem  <= '0;
			prep_s0.root <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	sq_st_t stage_s [SQRT_STEPS];
	logic   vld_s   [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam int PairIdx = SQRT_STEPS - 1 - k;
		sq_st_t      cur, nxt;
		logic        vin, ge;
		logic [20:0] tr, trial;

		if (k == 0) begin : g_first
			assign cur = prep_s0;
			assign vin = vld_s0;
		end else begin : g_next
			assign cur = stage_s[k-1];
			assign vin = vld_s[k-1];
		end

		// Bring down the next two radicand bits, try root*4+1
		assign tr    = {cur.rem, cur.x[2*PairIdx +: 2]};
		assign trial = {2'b0, cur.root, 2'b01};
		assign ge    = tr >= trial;

		always_comb begin
			nxt      = cur;
			nxt.rem  = ge ? 19'(tr - trial) : tr[18:0];
			nxt.root = {cur.root[15:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vin;
			end
		end
	end

	// Transmitted cosine only when going to a lower index
	sq_st_t last;
	assign last      = stage_s[SQRT_STEPS-1];
	assign out_valid = vld_s[SQRT_STEPS-1];

	always_comb begin
		out_word.tir = last.tir;
		out_word.c   = last.gt ? last.root : last.c;
		out_word.r0  = last.r0;
	end

endmodule

`default_nettype wire

// File: hdl/srf_back.sv
// Back end: (1-c)^5 by four truncating multiplies, the blend with r0,
// rounding to Q1.15 and saturation. Six stages. Depends on srf_pkg.
`default_nettype none

module srf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire srf_pkg::back_in_t in_word,
	output logic                   out_valid,
	output srf_pkg::result_t       out_word
);
	import srf_pkg::*;

	logic [16:0] omc;
	logic [16:0] omc_s1, omc_s2, omc_s3;
	logic [16:0] p_s1, p_s2, p_s3, p_s4;
	logic [32:0] r0_s1, r0_s2, r0_s3, r0_s4, r0_s5;
	logic [32:0] m_s5;
	logic        tir_s1, tir_s2, tir_s3, tir_s4, tir_s5;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign omc = 17'(ONE_Q16 - in_word.c);

	// Power chain, each product truncated back to Q1.16
	logic [33:0] pr1, pr2, pr3, pr4;
	assign pr1 = 34'(omc) * 34'(omc);
	assign pr2 = 34'(p_s1) * 34'(omc_s1);
	assign pr3 = 34'(p_s2) * 34'(omc_s2);
	assign pr4 = 34'(p_s3) * 34'(omc_s3);

	// Blend: (1 - r0) * p in Q1.32
	logic [49:0] blend;
	assign blend = 50'(ONE_Q32 - r0_s4) * 50'(p_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			omc_s1 <= omc;
			p_s1   <= pr1[32:16];
			r0_s1  <= in_word.r0;
			tir_s1 <= in_word.tir;
			omc_s2 <= omc_s1;
			p_s2   <= pr2[32:16];
			r0_s2  <= r0_s1;
			tir_s2 <= tir_s1;
			omc_s3 <= omc_s2;
			p_s3   <= pr3[32:16];
			r0_s3  <= r0_s2;
			tir_s3 <= tir_s2;
			p_s4   <= pr4[32:16];
			r0_s4  <= r0_s3;
			tir_s4 <= tir_s3;
			m_s5   <= blend[48:16];
			r0_s5  <= r0_s4;
			tir_s5 <= tir_s4;
		end
	end

	// Round half up to Q1.15 and saturate
	logic [33:0] res;
	logic [16:0] q15;
	assign res = 34'(r0_s5) + 34'(m_s5) + HALF_Q17;
	assign q15 = res[33:17];

	always_ff @(posedge clk) begin
		if (en) begin
			if (tir_s5) begin
				out_word.reflectance    <= R_ONE_Q15;
				out_word.total_internal <= 1'b1;
			end else begin
				out_word.reflectance    <= (q15 > 17'(R_ONE_Q15)) ? R_ONE_Q15 : q15[15:0];
				out_word.total_internal <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			out_valid <= vld_s5;
		end
	end

endmodule

`default_nettype wire

// File: hdl/schlick_reflectance.sv
// Schlick reflectance unit: takes one word per cycle while item_stall is low
// and returns one result word per input, in order, through 5 front-end stages,
// 33 divider stages, 18 square-root stages and 6 back-end stages. The two long divisions
// and the square root are unrolled one bit per stage, which sets the depth.
// The whole pipeline advances together; item_stall is high exactly when a
// result is waiting at the output and result_stall holds it there.
// Depends on srf_pkg and the srf_front, srf_div, srf_sqrt, srf_back modules.
`default_nettype none

module schlick_reflectance (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire srf_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output srf_pkg::result_t      result
);
	import srf_pkg::*;

	logic     en;
	logic     div_valid, sqrt_valid, back_valid;
	div_in_t  div_word;
	sqrt_in_t sqrt_word;
	back_in_t back_word;

	// Global advance: hold everything while the output word is stalled
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	srf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.in_word   (item),
		.out_valid (div_valid),
		.out_word  (div_word)
	);

	srf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_word   (div_word),
		.out_valid (sqrt_valid),
		.out_word  (sqrt_word)
	);

	srf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sqrt_valid),
		.in_word   (sqrt_word),
		.out_valid (back_valid),
		.out_word  (back_word)
	);

	srf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (back_valid),
		.in_word   (back_word),
		.out_valid (result_valid),
		.out_word  (result)
	);

endmodule

`default_nettype wire

// File: hdl/srf_chk.sv
// Port-level checks for the Schlick reflectance unit, bound to the top level.
// Depends on srf_pkg.
`default_nettype none

module srf_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire srf_pkg::item_t   item,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire srf_pkg::result_t result
);
	import srf_pkg::*;

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// Input backpressure only comes from a held output word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without output backpressure");

	// Total internal reflection always reports full reflectance
	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.total_internal |-> result.reflectance == R_ONE_Q15)
		else $error("total internal reflection without reflectance one");

	// Reflectance saturates at one
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.reflectance <= R_ONE_Q15)
		else $error("reflectance above one");

endmodule

bind schlick_reflectance srf_chk u_srf_chk (.*);

`default_nettype wire

// File: verif/tb_schlick_reflectance.sv
// Testbench for schlick_reflectance: drives random and corner input words,
// predicts each result with a fixed-point Schlick model and checks in order.
// Depends on srf_pkg and the schlick_reflectance RTL.
`default_nettype none

class reflect_board;
	srf_pkg::result_t pending[$];
	int errors;

	function automatic logic [32:0] root33(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h1_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[32:0];
	endfunction

	// Expected result for one input word
	function automatic srf_pkg::result_t reflect(srf_pkg::item_t w);
		srf_pkg::result_t o;
		longint dot;
		logic [63:0] c, n1, n2, omc2, num, den, sin2, d, s, r0, omc, p, res, q;
		dot = longint'(w.eye_x) * longint'(w.normal_x)
			+ longint'(w.eye_y) * longint'(w.normal_y)
			+ longint'(w.eye_z) * longint'(w.normal_z);
		if (dot < 0) dot = 0;
		if (dot > 64'h1000_0000) dot = 64'h1000_0000;
		c = dot >> 12;
		n1 = 64'(w.index_from);
		n2 = 64'(w.index_to);
		o.total_internal = 1'b0;
		if (n1 > n2) begin
			omc2 = 64'h1_0000_0000 - c * c;
			num = n1 * n1 * omc2;
			den = n2 * n2;
			if (num > (den << 32)) begin
				o.reflectance = 16'h8000;
				o.total_internal = 1'b1;
				return o;
			end
			sin2 = (den != 0) ? num / den : '0;
			if (sin2 > 64'h1_0000_0000) sin2 = 64'h1_0000_0000;
			c = 64'(root33(64'h1_0000_0000 - sin2));
		end
		d = (n1 > n2) ? n1 - n2 : n2 - n1;
		s = n1 + n2;
		r0 = (s != 0) ? ((d * d) << 32) / (s * s) : '0;
		if (r0 > 64'h1_0000_0000) r0 = 64'h1_0000_0000;
		omc = 64'h1_0000 - c;
		p = omc;
		for (int i = 1; i < 5; i++) p = (p * omc) >> 16;
		res = r0 + (((64'h1_0000_0000 - r0) * p) >> 16);
		q = (res + 64'h1_0000) >> 17;
		if (q > 64'h8000) q = 64'h8000;
		o.reflectance = q[15:0];
		return o;
	endfunction

	function void note_word(srf_pkg::item_t w);
		pending = {pending, reflect(w)};
	endfunction

	function void check_result(srf_pkg::result_t got);
		srf_pkg::result_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.reflectance !== exp_r.reflectance) begin
			$display("%0t: reflectance expected %0d actual %0d", $time,
				exp_r.reflectance, got.reflectance);
			errors++;
		end
		if (got.total_internal !== exp_r.total_internal) begin
			$display("%0t: total_internal expected %0b actual %0b", $time,
				exp_r.total_internal, got.total_internal);
			errors++;
		end
	endfunction
endclass

module tb_schlick_reflectance;
	timeunit 1ns;
	timeprecision 1ps;
	import srf_pkg::*;

	localparam int WATCH_LIMIT = 2000;
	localparam int RANDOM_WORDS = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	reflect_board board = new();
	bit quiet = 1'b0;
	int idle_cycles = 0;

	schlick_reflectance DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Note accepted words, check results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) board.note_word(item);
			if (result_valid && !result_stall) board.check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCH_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Random stall bursts on the result side
	always @(negedge clk) begin
		if (quiet || $urandom_range(0, 7) != 0) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= 1'b1;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
	end

	// Present one word and hold it until taken
	task automatic send_word(item_t w);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] comp();
		case ($urandom_range(0, 4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [13:0] index_val();
		case ($urandom_range(0, 5))
			0: return 14'h3FFF;
			1: return 14'd0;
			2: return 14'($urandom_range(0, 4095));
			default: return 14'($urandom_range(4096, 16383));
		endcase
	endfunction

	// Roughly unit vectors; the mix of signs gives both clamps
	function automatic item_t random_word();
		item_t w;
		int k;
		k = $urandom_range(0, 9);
		if (k < 6) begin
			w.normal_x = '0;
			w.normal_y = '0;
			w.normal_z = 16'sd16384;
			w.eye_x = 16'($urandom_range(0, 16000) - 8000);
			w.eye_y = 16'($urandom_range(0, 16000) - 8000);
			w.eye_z = 16'($urandom_range(0, 20000) - 3000);
		end else begin
			w.eye_x = comp(); w.eye_y = comp(); w.eye_z = comp();
			w.normal_x = comp(); w.normal_y = comp(); w.normal_z = comp();
		end
		w.index_from = index_val();
		w.index_to = ($urandom_range(0, 7) == 0) ? w.index_from : index_val();
		return w;
	endfunction

	function automatic item_t make_word(int ex, int ey, int ez, int nx, int ny, int nz,
		int n1, int n2);
		item_t w;
		w.eye_x = 16'(ex); w.eye_y = 16'(ey); w.eye_z = 16'(ez);
		w.normal_x = 16'(nx); w.normal_y = 16'(ny); w.normal_z = 16'(nz);
		w.index_from = 14'(n1); w.index_to = 14'(n2);
		return w;
	endfunction

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Corner words: head-on, grazing, back side, over-long vectors,
		// total internal reflection, zero and sub-unity indices, equal indices
		send_word(make_word(0, 0, 16384, 0, 0, 16384, 4096, 6144));
		send_word(make_word(16384, 0, 0, 0, 0, 16384, 4096, 6144));
		send_word(make_word(0, 0, -16384, 0, 0, 16384, 6144, 4096));
		send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 6144, 4096));
		send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, 4096, 4096));
		send_word(make_word(-32768, 0, 0, 32767, 0, 0, 16383, 4096));
		send_word(make_word(4000, 0, 15800, 0, 0, 16384, 6144, 4096));
		send_word(make_word(12000, 0, 11000, 0, 0, 16384, 6144, 4096));
		send_word(make_word(4000, 0, 15800, 0, 0, 16384, 6144, 0));
		send_word(make_word(0, 0, 16384, 0, 0, 16384, 6144, 0));
		send_word(make_word(8000, 0, 14000, 0, 0, 16384, 0, 0));
		send_word(make_word(8000, 0, 14000, 0, 0, 16384, 2048, 1000));
		send_word(make_word(8000, 0, 14000, 0, 0, 16384, 0, 16383));
		send_word(make_word(8000, 0, 14000, 0, 0, 16384, 16383, 16383));
		send_word(make_word(8000, 0, 14000, 0, 0, 16384, 16383, 16382));
		send_word(make_word(16384, 0, 0, 0, 0, 16384, 16383, 16382));
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS - 100) quiet = 1'b1;
			send_word(random_word());
		end
		item_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

`default_nettype wire
